@@ design/gpe_pkg.sv @@
package gpe_pkg;

  localparam int PORT_W  = 16;
  localparam int SLOT_N  = 8;
  localparam int ENTRY_W = 8;
  localparam int TIME_W  = 32;
  localparam int CFG_W   = 64;
  localparam int CIDX_W  = 2;
  localparam int CHAN_W  = 4;

  typedef enum logic [1:0] {
    MODE_WR_OE   = 2'd0,
    MODE_WR_MASK = 2'd1,
    MODE_RD_OUT  = 2'd2,
    MODE_RD_IN   = 2'd3
  } mode_t;

  localparam logic [CIDX_W-1:0] CFG_OUTPUT_ENABLE = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_MODULE_INDEX  = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_IRQ_SOURCES   = 2'd2;

  // bit positions inside one slot entry
  localparam int ENT_ANALOG = 7;
  localparam int ENT_MODULE = 6;
  localparam int ENT_CH_HI  = 5;
  localparam int ENT_CH_LO  = 2;
  localparam int ENT_RISE   = 1;
  localparam int ENT_FALL   = 0;

  typedef struct packed {
    logic [PORT_W-1:0]         output_enable;
    logic                      module_index;
    logic [SLOT_N*ENTRY_W-1:0] irq_sources;
  } cfg_t;

  typedef struct packed {
    mode_t             mode;
    logic [PORT_W-1:0] port_value;
    logic [PORT_W-1:0] pin_mask;
    logic [TIME_W-1:0] local_time;
  } req_t;

  typedef struct packed {
    logic [PORT_W-1:0] read_data;
    logic [SLOT_N-1:0] irq_fired;
    logic [TIME_W-1:0] irq_time;
  } res_t;

endpackage

@@ design/gpe_edge_match.sv @@
module gpe_edge_match
  import gpe_pkg::*;
#(
  parameter int CHANNELS  = 16,
  parameter int IRQ_SLOTS = 8
) (
  input  req_t              req,
  input  cfg_t              cfg,
  input  logic [PORT_W-1:0] levels,
  output logic [PORT_W-1:0] levels_nxt,
  output res_t              res
);

  // channels past the port width can never change
  localparam int CH_EFF = (CHANNELS < PORT_W) ? CHANNELS : PORT_W;

  logic              is_write;
  logic [PORT_W-1:0] upd_mask;
  logic [PORT_W-1:0] changed;
  logic [SLOT_N-1:0] fired;

  always_comb begin
    is_write = 1'b0;
    upd_mask = '0;
    unique case (req.mode)
      MODE_WR_OE: begin
        is_write = 1'b1;
        upd_mask = cfg.output_enable;
      end
      MODE_WR_MASK: begin
        is_write = 1'b1;
        upd_mask = req.pin_mask;
      end
      MODE_RD_OUT, MODE_RD_IN: begin
        is_write = 1'b0;
        upd_mask = '0;
      end
      default: begin
        is_write = 1'b0;
        upd_mask = '0;
      end
    endcase
  end

  assign changed = upd_mask & (req.port_value ^ levels);

  // each slot watches exactly one channel, so index the changed bits by it
  always_comb begin
    logic [ENTRY_W-1:0] ent;
    logic [CHAN_W-1:0]  ch;
    logic               hit;
    fired = '0;
    for (int t = 0; t < SLOT_N; t++) begin
      ent = cfg.irq_sources[t*ENTRY_W +: ENTRY_W];
      ch  = ent[ENT_CH_HI:ENT_CH_LO];
      hit = !ent[ENT_ANALOG] && (ent[ENT_MODULE] == cfg.module_index) &&
            ({1'b0, ch} < (CHAN_W+1)'(CH_EFF)) && changed[ch] &&
            ((ent[ENT_RISE] && req.port_value[ch]) ||
             (ent[ENT_FALL] && !req.port_value[ch]));
      fired[t] = (t < IRQ_SLOTS) ? hit : 1'b0;
    end
  end

  assign levels_nxt = (levels & ~upd_mask) | (req.port_value & upd_mask);

  always_comb begin
    res.irq_fired = is_write ? fired : '0;
    res.irq_time  = (is_write && (fired != '0)) ? req.local_time : '0;
    case (req.mode)
      MODE_RD_OUT: res.read_data = levels & cfg.output_enable;
      MODE_RD_IN:  res.read_data = levels & ~cfg.output_enable;
      default:     res.read_data = '0;
    endcase
  end

endmodule

@@ design/gpio_port_edge_interrupt_top.sv @@
// Channel  | Direction | Handshake             | Payload
// input    | in        | in_valid / in_stall   | in_mode, in_port_value, in_pin_mask,
//          |           |                       | in_local_time
// result   | out       | out_valid / out_stall | out_read_data, out_irq_fired, out_irq_time
// config   | in        | cfg_we                | cfg_index, cfg_wdata
//
// One request per cycle sustained while the result side is not stalled; an accepted
// request passes through the input register, then the result register, with the
// edge/slot match logic between them.
// Synchronous active-low reset clears both valid flags, the port levels and all
// configuration registers.
// A stalled result holds; the input side stalls only when the input register is full
// and the result register cannot take its contents.
module gpio_port_edge_interrupt_top
  import gpe_pkg::*;
#(
  parameter int CHANNELS  = 16,
  parameter int IRQ_SLOTS = 8
) (
  input  logic              clk,
  input  logic              rst_n,

  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_mode,
  input  logic [PORT_W-1:0] in_port_value,
  input  logic [PORT_W-1:0] in_pin_mask,
  input  logic [TIME_W-1:0] in_local_time,

  output logic              out_valid,
  input  logic              out_stall,
  output logic [PORT_W-1:0] out_read_data,
  output logic [SLOT_N-1:0] out_irq_fired,
  output logic [TIME_W-1:0] out_irq_time,

  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  cfg_t              cfg_r;
  logic [PORT_W-1:0] levels_r;
  logic [PORT_W-1:0] levels_nxt;
  logic              s1_valid_r;
  req_t              s1_req_r;
  logic              out_valid_r;
  res_t              out_res_r;
  res_t              res_nxt;
  logic              in_acc;
  logic              adv;

  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OUTPUT_ENABLE: cfg_r.output_enable <= cfg_wdata[PORT_W-1:0];
        CFG_MODULE_INDEX:  cfg_r.module_index  <= cfg_wdata[0];
        CFG_IRQ_SOURCES:   cfg_r.irq_sources   <= cfg_wdata[SLOT_N*ENTRY_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      levels_r    <= '0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
        levels_r    <= levels_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_req_r.mode       <= mode_t'(in_mode);
      s1_req_r.port_value <= in_port_value;
      s1_req_r.pin_mask   <= in_pin_mask;
      s1_req_r.local_time <= in_local_time;
    end
    if (adv) begin
      out_res_r <= res_nxt;
    end
  end

  gpe_edge_match #(
    .CHANNELS  (CHANNELS),
    .IRQ_SLOTS (IRQ_SLOTS)
  ) u_match (
    .req        (s1_req_r),
    .cfg        (cfg_r),
    .levels     (levels_r),
    .levels_nxt (levels_nxt),
    .res        (res_nxt)
  );

  assign out_valid     = out_valid_r;
  assign out_read_data = out_res_r.read_data;
  assign out_irq_fired = out_res_r.irq_fired;
  assign out_irq_time  = out_res_r.irq_time;

  a_rd_no_irq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_read_data != '0)) |-> (out_irq_fired == '0))
    else $error("read result carries interrupt bits");

  a_stamp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_irq_fired == '0)) |-> (out_irq_time == '0))
    else $error("timestamp without fired slot");

  a_levels_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(levels_r))
    else $error("port levels changed without a request moving");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled while the pipeline can move");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

import gpe_pkg::*;

// Tracks the port state and register copies, predicts one response per request
// and compares it against what comes out of the result channel.
class gpio_scoreboard;
  logic [PORT_W-1:0]         dir_out;
  logic                      module_sel;
  logic [SLOT_N*ENTRY_W-1:0] slot_table;
  logic [PORT_W-1:0]         levels;
  res_t                      pending_responses[$];
  int                        mismatches;
  int                        requests;
  int                        writes;
  int                        reads;
  int                        fired_responses;
  int                        reg_writes;

  function new();
    dir_out         = '0;
    module_sel      = 1'b0;
    slot_table      = '0;
    levels          = '0;
    mismatches      = 0;
    requests        = 0;
    writes          = 0;
    reads           = 0;
    fired_responses = 0;
    reg_writes      = 0;
  endfunction

  function void write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] data);
    reg_writes++;
    case (idx)
      CFG_OUTPUT_ENABLE: dir_out    = data[PORT_W-1:0];
      CFG_MODULE_INDEX:  module_sel = data[0];
      CFG_IRQ_SOURCES:   slot_table = data;
      default: ;  // no register behind this index
    endcase
  endfunction

  function res_t port_response(req_t r);
    res_t              o;
    logic [PORT_W-1:0] m;
    logic [ENTRY_W-1:0] e;
    logic              rise;
    o = '0;
    case (r.mode)
      MODE_RD_OUT: o.read_data = levels & dir_out;
      MODE_RD_IN:  o.read_data = levels & ~dir_out;
      default: begin
        m = (r.mode == MODE_WR_OE) ? dir_out : r.pin_mask;
        for (int i = 0; i < PORT_W; i++) begin
          if (m[i] && (r.port_value[i] != levels[i])) begin
            rise = r.port_value[i];
            for (int t = 0; t < SLOT_N; t++) begin
              e = slot_table[t*ENTRY_W +: ENTRY_W];
              if (!e[ENT_ANALOG] && (e[ENT_MODULE] == module_sel) &&
                  (e[ENT_CH_HI:ENT_CH_LO] == CHAN_W'(i)) &&
                  ((e[ENT_RISE] && rise) || (e[ENT_FALL] && !rise)))
                o.irq_fired[t] = 1'b1;
            end
          end
        end
        levels = (levels & ~m) | (r.port_value & m);
        if (o.irq_fired != '0) o.irq_time = r.local_time;
      end
    endcase
    return o;
  endfunction

  function void take_request(req_t r);
    res_t o;
    o = port_response(r);
    requests++;
    if (r.mode == MODE_WR_OE || r.mode == MODE_WR_MASK) writes++;
    else reads++;
    if (o.irq_fired != '0) fired_responses++;
    pending_responses.push_back(o);
  endfunction

  function void check_response(res_t got);
    res_t exp_r;
    if (pending_responses.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: response with nothing pending: rd=%h fired=%h time=%h",
                 got.read_data, got.irq_fired, got.irq_time);
      return;
    end
    exp_r = pending_responses.pop_front();
    if (got.read_data !== exp_r.read_data || got.irq_fired !== exp_r.irq_fired ||
        got.irq_time !== exp_r.irq_time) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: response mismatch: rd %h/%h fired %h/%h time %h/%h (exp/got)",
                 exp_r.read_data, got.read_data, exp_r.irq_fired, got.irq_fired,
                 exp_r.irq_time, got.irq_time);
    end
  endfunction

  function int pending();
    return pending_responses.size();
  endfunction
endclass

module testbench;

  localparam logic [CIDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_ITEMS    = 300;

  logic              clk           = 1'b0;
  logic              rst_n         = 1'b0;
  logic              in_valid      = 1'b0;
  logic              in_stall;
  logic [1:0]        in_mode       = '0;
  logic [PORT_W-1:0] in_port_value = '0;
  logic [PORT_W-1:0] in_pin_mask   = '0;
  logic [TIME_W-1:0] in_local_time = '0;
  logic              out_valid;
  logic              out_stall     = 1'b0;
  logic [PORT_W-1:0] out_read_data;
  logic [SLOT_N-1:0] out_irq_fired;
  logic [TIME_W-1:0] out_irq_time;
  logic              cfg_we        = 1'b0;
  logic [CIDX_W-1:0] cfg_index     = '0;
  logic [CFG_W-1:0]  cfg_wdata     = '0;

  gpio_scoreboard sb;
  int  idle_cycles = 0;
  bit  calm        = 1'b0;
  bit  hold_req    = 1'b0;
  bit  hold_active = 1'b0;
  int  holds_done  = 0;

  always #2 clk = ~clk;

  gpio_port_edge_interrupt_top u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_mode       (in_mode),
    .in_port_value (in_port_value),
    .in_pin_mask   (in_pin_mask),
    .in_local_time (in_local_time),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_read_data (out_read_data),
    .out_irq_fired (out_irq_fired),
    .out_irq_time  (out_irq_time),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  // sample handshakes with pre-edge values
  always @(posedge clk) begin
    req_t r;
    res_t o;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        o.read_data = out_read_data;
        o.irq_fired = out_irq_fired;
        o.irq_time  = out_irq_time;
        sb.check_response(o);
      end
      if (in_valid && !in_stall) begin
        r.mode       = mode_t'(in_mode);
        r.port_value = in_port_value;
        r.pin_mask   = in_pin_mask;
        r.local_time = in_local_time;
        sb.take_request(r);
      end
      if (cfg_we) sb.write_reg(cfg_index, cfg_wdata);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : watchdog
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("ERROR: no handshake for %0d cycles, %0d responses outstanding",
             WATCHDOG_LIMIT, sb.pending());
    $display("testbench: FAIL");
    $finish;
  end

  // result side back-pressure, plus the long hold-off on request
  initial begin : result_stall
    bit s;
    int n;
    forever begin
      if (hold_req) begin
        hold_req    = 1'b0;
        hold_active = 1'b1;
        out_stall  <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active = 1'b0;
        holds_done++;
      end else begin
        if (calm) begin
          s = 1'b0;
          n = 1;
        end else begin
          s = ($urandom_range(0, 2) == 0);
          n = s ? gap_len() : $urandom_range(1, 6);
        end
        out_stall <= s;
        repeat (n) @(posedge clk);
      end
    end
  end

  task automatic send(input mode_t m, input logic [PORT_W-1:0] v,
                      input logic [PORT_W-1:0] pm, input logic [TIME_W-1:0] t);
    in_valid      <= 1'b1;
    in_mode       <= m;
    in_port_value <= v;
    in_pin_mask   <= pm;
    in_local_time <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic input_gap();
    int n;
    n = (calm || $urandom_range(0, 2) != 0) ? 0 : gap_len();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // drop in_valid and wait for the clock first, so the last accepted request is already in the scoreboard
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    @(posedge clk);
  endtask

  task automatic reconfigure(input logic [PORT_W-1:0] oe, input logic mi,
                             input logic [CFG_W-1:0] src);
    settle();
    cfg_write(CFG_OUTPUT_ENABLE, {$urandom, $urandom} & ~64'hFFFF | CFG_W'(oe));
    cfg_write(CFG_MODULE_INDEX, {$urandom, $urandom} & ~64'h1 | CFG_W'(mi));
    cfg_write(CFG_IRQ_SOURCES, src);
    // an index with no register behind it must change nothing
    cfg_write(CFG_UNUSED, {$urandom, $urandom});
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [CFG_W-1:0] random_slots(logic mi);
    logic [CFG_W-1:0]   src;
    logic [ENTRY_W-1:0] e;
    for (int t = 0; t < SLOT_N; t++) begin
      e = ENTRY_W'($urandom_range(0, 255));
      if ($urandom_range(0, 3) != 0) e[ENT_ANALOG] = 1'b0;
      if ($urandom_range(0, 3) != 0) e[ENT_MODULE] = mi;
      src[t*ENTRY_W +: ENTRY_W] = e;
    end
    return src;
  endfunction

  task automatic random_request();
    mode_t             m;
    logic [PORT_W-1:0] v;
    logic [PORT_W-1:0] pm;
    logic [TIME_W-1:0] t;
    int                k;
    k = $urandom_range(0, 9);
    m = (k < 3) ? MODE_WR_OE : (k < 6) ? MODE_WR_MASK : (k < 8) ? MODE_RD_OUT : MODE_RD_IN;
    case ($urandom_range(0, 3))
      0:       v = sb.levels ^ (PORT_W'(1) << $urandom_range(0, PORT_W-1));
      1:       v = ~sb.levels;
      default: v = PORT_W'($urandom);
    endcase
    case ($urandom_range(0, 7))
      0:       pm = '1;
      1:       pm = '0;
      2:       pm = PORT_W'(1) << $urandom_range(0, PORT_W-1);
      default: pm = PORT_W'($urandom);
    endcase
    case ($urandom_range(0, 15))
      0:       t = '0;
      1:       t = '1;
      default: t = $urandom;
    endcase
    send(m, v, pm, t);
  endtask

  initial begin : stimulus
    logic [PORT_W-1:0] oe;
    logic              mi;
    logic [CFG_W-1:0]  src;
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reads straight after reset see cleared levels and direction
    send(MODE_RD_OUT, 16'hFFFF, 16'hFFFF, 32'h1);
    send(MODE_WR_OE, 16'hFFFF, 16'hFFFF, 32'h2);  // output enable still zero

    // slots: ch0 rise, ch0 fall, ch15 both, analog ch1, other module ch1,
    // ch1 with no edge enabled, ch5 rise, ch15 rise
    reconfigure(16'hFFFF, 1'b0, 64'h3E16_0447_873F_0102);
    send(MODE_WR_OE, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF);
    send(MODE_RD_OUT, 16'h0000, 16'h0000, 32'h0);
    send(MODE_RD_IN, 16'h0000, 16'h0000, 32'h0);
    send(MODE_WR_OE, 16'hFFFF, 16'h0000, 32'h1);   // no change, no interrupt
    send(MODE_WR_OE, 16'h0000, 16'hFFFF, 32'h0);
    send(MODE_WR_MASK, 16'hFFFF, 16'h0000, 32'h5);
    send(MODE_WR_MASK, 16'h0001, 16'h0001, 32'h1234_5678);
    send(MODE_WR_MASK, 16'h0000, 16'hFFFF, 32'h8765_4321);
    send(MODE_WR_MASK, 16'h8020, 16'h8020, 32'hDEAD_BEEF);  // rising edges on ch5 and ch15 together
    send(MODE_WR_MASK, 16'h8022, 16'h0002, 32'hA5A5_A5A5);
    send(MODE_RD_IN, 16'h0000, 16'h0000, 32'h0);

    reconfigure(16'h0000, 1'b1, 64'h3E16_0447_873F_0102);
    send(MODE_WR_OE, 16'h0000, 16'hFFFF, 32'h77);
    send(MODE_RD_IN, 16'h0000, 16'h0000, 32'h0);
    send(MODE_RD_OUT, 16'h0000, 16'h0000, 32'h0);
    send(MODE_WR_MASK, 16'h0000, 16'h0002, 32'h5A5A_5A5A);
    send(MODE_WR_MASK, 16'hFFFF, 16'hFFFF, 32'h0F0F_0F0F);

    reconfigure(16'hA5A5, 1'b0, '1);
    send(MODE_WR_OE, 16'h0000, 16'h0000, 32'hCAFE_0001);
    send(MODE_RD_OUT, 16'h0000, 16'h0000, 32'h0);
    send(MODE_RD_IN, 16'h0000, 16'h0000, 32'h0);

    for (int p = 0; p < 6; p++) begin
      mi = 1'($urandom_range(0, 1));
      oe = PORT_W'($urandom);
      case (p)
        0: begin oe = '1; mi = 1'b0; src = random_slots(mi); end
        1: begin oe = '0; mi = 1'b1; src = random_slots(mi); end
        2: src = '1;
        3: begin mi = 1'b1; src = '0; end
        default: src = random_slots(mi);
      endcase
      reconfigure(oe, mi, src);
      calm = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == 40) calm = 1'b0;
        if (p == 1 && i == 100) begin
          // long result hold-off while requests keep coming
          hold_req = 1'b1;
          wait (hold_active);
          repeat (12) random_request();
        end
        random_request();
        input_gap();
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Covered %0d requests (%0d writes, %0d reads), %0d with interrupts fired,",
             sb.requests, sb.writes, sb.reads, sb.fired_responses);
    $display("%0d register writes, %0d long result hold-offs, %0d mismatches.",
             sb.reg_writes, holds_done, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
